[hdl/smd_pkg.sv]
// ----------------------------------------------------------------------------
// smd_pkg
// Shared types and constants for the serial message deframer.
// ----------------------------------------------------------------------------
package smd_pkg;

    // Byte values with a fixed meaning on the link
    localparam logic [7:0] FRAME_END     = 8'hFF;
    localparam logic [7:0] CSUM_CLAMP    = 8'hFE;
    localparam logic [7:0] VERSION_RESET = 8'h30;   // ASCII zero

    // Frame layout: version, two name bytes, length, payload, checksum
    localparam int POS_VERSION  = 0;
    localparam int POS_NAME0    = 1;
    localparam int POS_NAME1    = 2;
    localparam int POS_LENGTH   = 3;
    localparam int HDR_BYTES    = 4;   // first payload byte
    localparam int LEN_OVERHEAD = 5;   // stored bytes that are not payload
    localparam int HI_SHIFT     = 7;   // high byte weight in a value

    // APB register map
    localparam int         APB_ADDR_W  = 3;
    localparam int         APB_DATA_W  = 32;
    localparam logic [0:0] REG_VERSION = 1'b0;

    typedef enum logic [2:0] {
        ST_GOOD        = 3'd0,
        ST_BAD_VERSION = 3'd1,
        ST_BAD_CSUM    = 3'd2,
        ST_BAD_LENGTH  = 3'd3,
        ST_OVERFLOW    = 3'd4
    } frame_status_t;

    typedef struct packed {
        logic [2:0]  frame_status;
        logic [7:0]  name_first;
        logic [7:0]  name_second;
        logic [14:0] decoded_value;
        logic [4:0]  value_index;
        logic        has_value;
        logic        last;
    } result_t;

    // Controller to datapath
    typedef struct packed {
        logic take_byte;   // non-terminator byte accepted
        logic frame_end;   // terminator accepted
        logic rd_issue;    // read the current value pair from the store
        logic load_pair;   // move the read pair into the output register
        logic next_pair;   // step to the following pair
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_term;     // byte on the input is a terminator
        logic multi;       // frame is good and carries at least one pair
        logic last_pair;   // current pair is the final one
        logic out_free;    // output register can take a result this cycle
    } dp_status_t;

endpackage

[hdl/smd_byte_if.sv]
// ----------------------------------------------------------------------------
// smd_byte_if
// Valid/ready channel carrying one received serial byte per transaction.
// ----------------------------------------------------------------------------
interface smd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

[hdl/smd_result_if.sv]
// ----------------------------------------------------------------------------
// smd_result_if
// Valid/ready channel carrying one decoded frame result per transaction.
// ----------------------------------------------------------------------------
interface smd_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  frame_status;
    logic [7:0]  name_first;
    logic [7:0]  name_second;
    logic [14:0] decoded_value;
    logic [4:0]  value_index;
    logic        has_value;
    logic        last;

    modport source (output valid, output frame_status, output name_first,
                    output name_second, output decoded_value, output value_index,
                    output has_value, output last, input ready);
    modport sink   (input valid, input frame_status, input name_first,
                    input name_second, input decoded_value, input value_index,
                    input has_value, input last, output ready);
endinterface

[hdl/smd_datapath.sv]
// ----------------------------------------------------------------------------
// smd_datapath
// Frame store, running checksum, header capture, frame checks, value pair
// read-out and the output register.
// ----------------------------------------------------------------------------
module smd_datapath
    import smd_pkg::*;
#(
    parameter int BUFFER_BYTES = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] rx_byte,
    input  logic [7:0] version_cfg,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output result_t    result,
    output logic       result_valid,
    input  logic       result_ready
);

    localparam int             CW        = $clog2(BUFFER_BYTES);
    localparam int             PW        = CW - 1;
    localparam logic [CW-1:0]  LAST_SLOT = CW'(BUFFER_BYTES - 1);

    logic [7:0]    mem [BUFFER_BYTES];

    logic [CW-1:0] byte_count_reg, byte_count_next;
    logic [7:0]    xor_reg, xor_next;
    logic          ovf_reg, ovf_next;
    logic [7:0]    version_reg, name0_reg, name1_reg, len_reg, last_byte_reg;
    logic [PW-1:0] pair_idx_reg, pair_idx_next;
    logic [PW-1:0] pairs_reg, pairs_next;
    logic [7:0]    lo_data_reg, hi_data_reg;
    result_t       result_reg, result_next;
    logic          result_valid_reg, result_valid_next;

    logic          can_store, do_store;
    logic          short_frame, csum_bad, len_bad, frame_good, no_pairs;
    logic [7:0]    sum, sum_clamped;
    logic [CW-1:0] len_expect;
    logic [6:0]    pairs_all;
    frame_status_t frame_status;
    logic [CW-1:0] addr_lo, addr_hi;
    logic          single_load;
    logic          out_free;

    // ---------------- byte capture ----------------
    assign can_store = !ovf_reg && (byte_count_reg < LAST_SLOT);
    assign do_store  = cmd.take_byte && can_store;

    always_comb
    begin
        byte_count_next = byte_count_reg;
        xor_next        = xor_reg;
        ovf_next        = ovf_reg;
        if (cmd.frame_end)
        begin
            byte_count_next = '0;
            xor_next        = '0;
            ovf_next        = 1'b0;
        end
        else if (do_store)
        begin
            byte_count_next = byte_count_reg + 1'b1;
            xor_next        = xor_reg ^ rx_byte;
        end
        else if (cmd.take_byte)
        begin
            ovf_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_store)
        begin
            mem[byte_count_reg] <= rx_byte;
            last_byte_reg       <= rx_byte;
            if (byte_count_reg == CW'(POS_VERSION)) version_reg <= rx_byte;
            if (byte_count_reg == CW'(POS_NAME0))   name0_reg   <= rx_byte;
            if (byte_count_reg == CW'(POS_NAME1))   name1_reg   <= rx_byte;
            if (byte_count_reg == CW'(POS_LENGTH))  len_reg     <= rx_byte;
        end
        if (cmd.rd_issue)
        begin
            lo_data_reg <= mem[addr_lo];
            hi_data_reg <= mem[addr_hi];
        end
        result_reg <= result_next;
    end

    // ---------------- frame checks at the terminator ----------------
    assign short_frame = byte_count_reg < CW'(LEN_OVERHEAD);
    assign sum         = xor_reg ^ last_byte_reg;   // checksum byte taken out
    assign sum_clamped = (sum == FRAME_END) ? CSUM_CLAMP : sum;
    assign csum_bad    = sum_clamped != last_byte_reg;
    assign len_expect  = byte_count_reg - CW'(LEN_OVERHEAD);
    assign len_bad     = {1'b0, len_reg} != 9'(len_expect);
    assign pairs_all   = len_reg[7:1];
    assign no_pairs    = pairs_all == '0;

    always_comb
    begin
        if (ovf_reg)                         frame_status = ST_OVERFLOW;
        else if (short_frame)                frame_status = ST_BAD_LENGTH;
        else if (version_reg != version_cfg) frame_status = ST_BAD_VERSION;
        else if (csum_bad)                   frame_status = ST_BAD_CSUM;
        else if (len_bad)                    frame_status = ST_BAD_LENGTH;
        else                                 frame_status = ST_GOOD;
    end

    assign frame_good = frame_status == ST_GOOD;

    // ---------------- pair sequencing ----------------
    always_comb
    begin
        pair_idx_next = pair_idx_reg;
        pairs_next    = pairs_reg;
        if (cmd.frame_end)
        begin
            pair_idx_next = '0;
            pairs_next    = pairs_all[PW-1:0];
        end
        else if (cmd.next_pair)
        begin
            pair_idx_next = pair_idx_reg + 1'b1;
        end
    end

    assign addr_lo = CW'({pair_idx_reg, 1'b0}) + CW'(HDR_BYTES);
    assign addr_hi = addr_lo + 1'b1;

    // ---------------- output register ----------------
    assign out_free    = !result_valid_reg || result_ready;
    assign single_load = cmd.frame_end && !(frame_good && !no_pairs);

    always_comb
    begin
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        if (single_load)
        begin
            // error or empty good frame: one result, names only when good
            result_next.frame_status  = frame_status;
            result_next.name_first    = frame_good ? name0_reg : 8'h00;
            result_next.name_second   = frame_good ? name1_reg : 8'h00;
            result_next.decoded_value = '0;
            result_next.value_index   = '0;
            result_next.has_value     = 1'b0;
            result_next.last          = 1'b1;
            result_valid_next         = 1'b1;
        end
        else if (cmd.load_pair)
        begin
            result_next.frame_status  = ST_GOOD;
            result_next.name_first    = name0_reg;
            result_next.name_second   = name1_reg;
            result_next.decoded_value = {7'b0, lo_data_reg}
                                      + 15'({hi_data_reg, {HI_SHIFT{1'b0}}});
            result_next.value_index   = 5'(pair_idx_reg);
            result_next.has_value     = 1'b1;
            result_next.last          = status.last_pair;
            result_valid_next         = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg   <= '0;
            xor_reg          <= '0;
            ovf_reg          <= 1'b0;
            pair_idx_reg     <= '0;
            pairs_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            byte_count_reg   <= byte_count_next;
            xor_reg          <= xor_next;
            ovf_reg          <= ovf_next;
            pair_idx_reg     <= pair_idx_next;
            pairs_reg        <= pairs_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign status.is_term   = rx_byte == FRAME_END;
    assign status.multi     = frame_good && !no_pairs;
    assign status.last_pair = ({1'b0, pair_idx_reg} + 1'b1) == {1'b0, pairs_reg};
    assign status.out_free  = out_free;

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= LAST_SLOT)
        else $error("frame store count beyond last slot");

    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.frame_end |=> (byte_count_reg == '0) && (xor_reg == '0) && !ovf_reg)
        else $error("frame state not cleared after terminator");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (single_load || cmd.load_pair) |-> out_free)
        else $error("result register overwritten before transfer");

    a_pair_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_issue |-> ({1'b0, pair_idx_reg} < {1'b0, pairs_reg}))
        else $error("value pair read beyond payload");

endmodule

[hdl/smd_ctrl.sv]
// ----------------------------------------------------------------------------
// smd_ctrl
// Sequencer: takes bytes, then walks the value pairs of a good frame.
// ----------------------------------------------------------------------------
module smd_ctrl
    import smd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    typedef enum logic [1:0] {
        S_ACCEPT,
        S_READ,
        S_LOAD
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign in_ready = (state_reg == S_ACCEPT) && status.out_free;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd.take_byte = accept && !status.is_term;
        cmd.frame_end = accept && status.is_term;
        cmd.rd_issue  = state_reg == S_READ;
        cmd.load_pair = (state_reg == S_LOAD) && status.out_free;
        cmd.next_pair = cmd.load_pair && !status.last_pair;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_ACCEPT:
            begin
                if (cmd.frame_end && status.multi)
                    state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (status.out_free)
                    state_next = status.last_pair ? S_ACCEPT : S_READ;
            end
            default:
            begin
                state_next = S_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_ACCEPT;
        else
            state_reg <= state_next;
    end

endmodule

[hdl/serial_message_deframer.sv]
// ----------------------------------------------------------------------------
// serial_message_deframer
// Buffers received serial bytes into frames and decodes their value pairs.
// ----------------------------------------------------------------------------
// Bytes enter on in_ch, one per transaction, while the block is collecting
// a frame. A 255 byte ends the frame; the frame is then checked (version,
// checksum, payload length) and results leave on out_ch. A failed, short,
// overflowed or empty frame gives one result, loaded into the output
// register in the terminator's own cycle. A good frame with N value pairs
// gives N results, each in turn: the low and high byte are first read from
// the frame store's two read ports into registers, then the decoded value
// is loaded into the output register once that register is free.
// Input is held off from the terminator until the last value of the frame
// sits in the output register, and whenever that register holds a result
// that out_ch is not taking. The frame store holds BUFFER_BYTES-1 bytes;
// further bytes are dropped and the frame reports overflow. The store needs
// no clearing after reset. The expected version register sits at APB byte
// address 0.
// ----------------------------------------------------------------------------
module serial_message_deframer
    import smd_pkg::*;
#(
    parameter int BUFFER_BYTES = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    smd_byte_if.sink              in_ch,
    smd_result_if.source          out_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [7:0] version_reg, version_next;
    logic       reg_sel;
    logic       cfg_write;
    dp_cmd_t    cmd;
    dp_status_t status;
    result_t    result;

    // ---------------- configuration ----------------
    // Register index is the address bit above the word offset.
    assign reg_sel   = paddr[APB_ADDR_W-1];
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_comb
    begin
        version_next = version_reg;
        if (cfg_write && (reg_sel == REG_VERSION))
            version_next = pwdata[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            version_reg <= VERSION_RESET;
        else
            version_reg <= version_next;
    end

    assign prdata = (reg_sel == REG_VERSION) ? APB_DATA_W'(version_reg) : '0;

    // ---------------- controller ----------------
    smd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .cmd      (cmd),
        .status   (status)
    );

    // ---------------- datapath ----------------
    smd_datapath #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .rx_byte          (in_ch.rx_byte),
        .version_cfg      (version_reg),
        .cmd              (cmd),
        .status           (status),
        .result           (result),
        .result_valid     (out_ch.valid),
        .result_ready     (out_ch.ready)
    );

    // ---------------- result channel ----------------
    assign out_ch.frame_status  = result.frame_status;
    assign out_ch.name_first    = result.name_first;
    assign out_ch.name_second   = result.name_second;
    assign out_ch.decoded_value = result.decoded_value;
    assign out_ch.value_index   = result.value_index;
    assign out_ch.has_value     = result.has_value;
    assign out_ch.last          = result.last;

endmodule

[test/serial_message_deframer_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_message_deframer_test
// Self-checking bench for the serial message deframer.
// ----------------------------------------------------------------------------
// A short directed table opens the run. It holds a lone terminator, a frame
// with extreme names and values, an empty frame and frames with a bad version
// and a bad checksum. Random frames follow under four protocol versions
// (0, 255, a random one, then ASCII zero again). Most are well formed and
// have random content. The rest have a clamped checksum, a wrong checksum,
// length or version, are short or overrun the store, or are noise. Every
// accepted byte runs through an internal model of the deframer, and each
// result transaction is compared field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module serial_message_deframer_test;
    import smd_pkg::*;

    localparam int STORE_BYTES   = 64;
    localparam int MIN_FRAME     = 6;       // shortest frame, terminator included
    localparam int FULL_PAIRS    = 29;      // pairs that exactly fill the store
    localparam int LONG_HOLD     = 200;     // receiver hold-off, in cycles
    localparam int SETTLE_CYCLES = 6;       // pause after the last result
    localparam int END_SETTLE    = 40;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int CYCLE_LIMIT   = 200000;

    localparam logic [APB_ADDR_W-1:0] VERSION_ADDR = APB_ADDR_W'(4 * REG_VERSION);

    typedef enum int {
        KIND_GOOD,
        KIND_CLAMPED,
        KIND_BAD_CSUM,
        KIND_BAD_LENGTH,
        KIND_BAD_VERSION,
        KIND_SHORT,
        KIND_NOISE,
        KIND_FULL,
        KIND_OVERFLOW
    } frame_kind_e;

    // One byte to send. Where fixed is set, want replaces the predicted result
    // of the frame that this byte terminates.
    typedef struct {
        logic [7:0] rx;
        bit         fixed;
        result_t    want;
    } byte_row_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    smd_byte_if   byte_link ();
    smd_result_if result_link ();

    serial_message_deframer #(
        .BUFFER_BYTES(STORE_BYTES)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (byte_link),
        .out_ch  (result_link),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // ------------------------------------------------------------------------
    // Shared state
    // ------------------------------------------------------------------------
    result_t    pending_results[$];   // expected result transactions, oldest first
    byte_row_t  byte_notes[$];        // one per byte offered, popped on acceptance
    logic [7:0] outgoing[$];          // frame being built for sending
    logic [7:0] expected_version;     // written by the stimulus side only
    bit         no_gaps = 1'b0;       // both sides stream without idling
    int         hold_requests = 0;    // long receiver hold-offs asked for
    int         check_errors = 0;
    int         flow_errors = 0;
    int         results_checked = 0;
    int         bytes_accepted = 0;
    int         status_count[5] = '{default: 0};
    int         cycle_count = 0;

    // Predictor state: mirror of the frame store and its running totals
    logic [7:0] store_bytes[STORE_BYTES];
    int         held_count = 0;
    logic [7:0] held_xor = 8'h00;
    bit         dropped = 1'b0;

    function automatic result_t error_result(input frame_status_t status);
        result_t r;
        r = '0;
        r.frame_status = status;
        r.last = 1'b1;
        return r;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int idle_run();
        if ($urandom_range(0, 99) < 85)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_gap();
        if (no_gaps || $urandom_range(0, 99) < 55)
        begin
            return 0;
        end
        return idle_run();
    endfunction

    // Payload bytes lean towards the 7-bit range the link is meant to carry
    function automatic logic [7:0] rand_payload();
        if ($urandom_range(0, 3) == 0)
        begin
            return 8'($urandom_range(0, 254));
        end
        return 8'($urandom_range(0, 127));
    endfunction

    function automatic logic [7:0] fold_outgoing();
        logic [7:0] acc;
        acc = 8'h00;
        foreach (outgoing[i])
        begin
            acc ^= outgoing[i];
        end
        return acc;
    endfunction

    function automatic frame_kind_e pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return KIND_GOOD;
        if (r < 62) return KIND_CLAMPED;
        if (r < 70) return KIND_BAD_CSUM;
        if (r < 78) return KIND_BAD_LENGTH;
        if (r < 85) return KIND_BAD_VERSION;
        if (r < 92) return KIND_SHORT;
        return KIND_NOISE;
    endfunction

    // ------------------------------------------------------------------------
    // Predictor: takes one accepted byte and queues the results it causes
    // ------------------------------------------------------------------------
    task automatic deframe_byte(input logic [7:0] value, input byte_row_t note);
        result_t    outcome[$];
        result_t    r;
        logic [7:0] tail;
        logic [7:0] csum;
        int         pairs;

        if (value != FRAME_END)
        begin
            // The terminator needs the last slot, so only STORE_BYTES-1 are kept
            if (!dropped && held_count < STORE_BYTES - 1)
            begin
                store_bytes[held_count] = value;
                held_count++;
                held_xor ^= value;
            end
            else
            begin
                dropped = 1'b1;
            end
        end
        else
        begin
            // Checks run in a fixed order: overflow, short, version, checksum,
            // length. The first that fails decides the single error result.
            if (dropped)
            begin
                outcome.push_back(error_result(ST_OVERFLOW));
            end
            else if (held_count + 1 < MIN_FRAME)
            begin
                outcome.push_back(error_result(ST_BAD_LENGTH));
            end
            else if (store_bytes[POS_VERSION] != expected_version)
            begin
                outcome.push_back(error_result(ST_BAD_VERSION));
            end
            else
            begin
                tail = store_bytes[held_count - 1];
                csum = held_xor ^ tail;
                if (csum == FRAME_END)
                begin
                    csum = CSUM_CLAMP;
                end
                if (csum != tail)
                begin
                    outcome.push_back(error_result(ST_BAD_CSUM));
                end
                else if (int'(store_bytes[POS_LENGTH]) != held_count - LEN_OVERHEAD)
                begin
                    outcome.push_back(error_result(ST_BAD_LENGTH));
                end
                else
                begin
                    // An odd length leaves one trailing byte unused
                    pairs = int'(store_bytes[POS_LENGTH]) / 2;
                    r = '0;
                    r.frame_status = ST_GOOD;
                    r.name_first = store_bytes[POS_NAME0];
                    r.name_second = store_bytes[POS_NAME1];
                    if (pairs == 0)
                    begin
                        r.last = 1'b1;
                        outcome.push_back(r);
                    end
                    for (int i = 0; i < pairs; i++)
                    begin
                        r.decoded_value = 15'(store_bytes[HDR_BYTES + 2 * i])
                            + (15'(store_bytes[HDR_BYTES + 2 * i + 1]) << HI_SHIFT);
                        r.value_index = 5'(i);
                        r.has_value = 1'b1;
                        r.last = (i + 1 == pairs);
                        outcome.push_back(r);
                    end
                end
            end

            status_count[int'(outcome[0].frame_status)]++;
            if (note.fixed)
            begin
                pending_results.push_back(note.want);
            end
            else
            begin
                foreach (outcome[i])
                begin
                    pending_results.push_back(outcome[i]);
                end
            end
            held_count = 0;
            held_xor = 8'h00;
            dropped = 1'b0;
        end
    endtask

    task automatic compare_field(input string field, input logic [14:0] want,
                                 input logic [14:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, field, want, got);
            check_errors++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Scoreboard: both channels sampled at the same edge. Input first, so a
    // terminator's expectations are queued before any result is matched.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : scoreboard
        byte_row_t note;
        result_t   got;
        result_t   want;

        if (rst_n === 1'b1)
        begin
            if (byte_link.valid === 1'b1 && byte_link.ready === 1'b1)
            begin
                bytes_accepted++;
                if (byte_notes.size() == 0)
                begin
                    $display("%0t ns: byte transaction accepted that was never offered",
                             $time);
                    check_errors++;
                end
                else
                begin
                    note = byte_notes.pop_front();
                    deframe_byte(byte_link.rx_byte, note);
                end
            end

            if (result_link.valid === 1'b1 && result_link.ready === 1'b1)
            begin
                got = '{result_link.frame_status, result_link.name_first,
                        result_link.name_second, result_link.decoded_value,
                        result_link.value_index, result_link.has_value,
                        result_link.last};
                results_checked++;
                if (pending_results.size() == 0)
                begin
                    $display("%0t ns: unexpected result transaction, expected none, actual %p",
                             $time, got);
                    check_errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    compare_field("frame_status", want.frame_status, got.frame_status);
                    compare_field("name_first", want.name_first, got.name_first);
                    compare_field("name_second", want.name_second, got.name_second);
                    compare_field("decoded_value", want.decoded_value, got.decoded_value);
                    compare_field("value_index", want.value_index, got.value_index);
                    compare_field("has_value", want.has_value, got.has_value);
                    compare_field("last", want.last, got.last);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t ns: timeout after %0d cycles", $time, CYCLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver: random runs of ready high and low. A hold-off request
    // from the stimulus side drops ready for a hold-off set by LONG_HOLD and
    // counted here, so the output register fills and the byte input backs up.
    // ------------------------------------------------------------------------
    initial
    begin : result_receiver
        int  holds_done;
        int  run;
        bit  level;

        holds_done = 0;
        result_link.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (holds_done < hold_requests)
            begin
                holds_done++;
                result_link.ready <= 1'b0;
                for (int held = 0; held < LONG_HOLD; held++)
                begin
                    @(posedge clk);
                end
            end
            else
            begin
                level = no_gaps || ($urandom_range(0, 99) < 65);
                run = level ? $urandom_range(1, 20) : idle_run();
                result_link.ready <= level;
                repeat (run) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Byte sender and APB helpers. All are entered just after a rising edge.
    // ------------------------------------------------------------------------

    // Offer one byte and return at the edge where the transaction completes.
    // valid stays high so a following byte can go out back to back.
    task automatic send_byte(input logic [7:0] value, input bit fixed, input result_t want);
        byte_row_t note;
        int        gap;

        gap = pick_gap();
        if (gap > 0)
        begin
            byte_link.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        note.rx = value;
        note.fixed = fixed;
        note.want = want;
        byte_notes.push_back(note);
        byte_link.valid <= 1'b1;
        byte_link.rx_byte <= value;
        do
        begin
            @(posedge clk);
        end
        while (byte_link.ready !== 1'b1);
    endtask

    task automatic stop_input();
        byte_link.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_frame();
        foreach (outgoing[i])
        begin
            send_byte(outgoing[i], 1'b0, '0);
        end
    endtask

    // Wait until every expected result has come, then let the block settle
    task automatic wait_results();
        int waited;

        waited = 0;
        while (waited < DRAIN_LIMIT && pending_results.size() != 0)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_results.size() != 0)
        begin
            $display("%0t ns: %0d expected result transactions never arrived",
                     $time, pending_results.size());
            flow_errors++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (pready !== 1'b1);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic reg_read(input logic [APB_ADDR_W-1:0] addr,
                            output logic [APB_DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (pready !== 1'b1);
        data = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_version(input logic [7:0] value);
        logic [APB_DATA_W-1:0] readback;

        reg_write(VERSION_ADDR, APB_DATA_W'(value));
        expected_version = value;
        reg_read(VERSION_ADDR, readback);
        if (readback !== APB_DATA_W'(value))
        begin
            $display("%0t ns: version register readback, expected %0d, actual %0d",
                     $time, value, readback);
            flow_errors++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Frame builder. Well-formed kinds take the current version, random names
    // and value pairs, an optional unpaired byte and a correct checksum; bad
    // kinds spoil one of those; short, noise and overflow are random bytes.
    // ------------------------------------------------------------------------
    task automatic build_frame(input frame_kind_e kind, input logic [7:0] ver);
        int         pairs;
        int         spare;
        logic [7:0] lead;
        logic [7:0] length;
        logic [7:0] wrong;
        logic [7:0] csum;
        logic [7:0] fold;

        outgoing.delete();
        case (kind)
            KIND_SHORT:
            begin
                repeat ($urandom_range(0, MIN_FRAME - 2)) outgoing.push_back(rand_payload());
            end
            KIND_NOISE:
            begin
                // stray terminators split the noise into junk frames
                repeat ($urandom_range(1, 12))
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        outgoing.push_back(FRAME_END);
                    end
                    else
                    begin
                        outgoing.push_back(8'($urandom_range(0, 254)));
                    end
                end
            end
            KIND_OVERFLOW:
            begin
                repeat ($urandom_range(STORE_BYTES, STORE_BYTES + 6))
                begin
                    outgoing.push_back(rand_payload());
                end
            end
            default:
            begin
                if (kind == KIND_FULL)
                begin
                    pairs = FULL_PAIRS;
                end
                else if ($urandom_range(0, 9) == 0)
                begin
                    pairs = 0;
                end
                else
                begin
                    pairs = $urandom_range(1, 6);
                end
                if (kind == KIND_CLAMPED && pairs == 0)
                begin
                    pairs = 1;
                end
                spare = (kind != KIND_FULL && $urandom_range(0, 3) == 0) ? 1 : 0;

                lead = ver;
                if (kind == KIND_BAD_VERSION)
                begin
                    while (lead == ver)
                    begin
                        lead = 8'($urandom_range(0, 254));
                    end
                end
                // a version of 255 cannot be sent: such frames fail on version
                if (lead == FRAME_END)
                begin
                    lead = 8'($urandom_range(0, 254));
                end
                outgoing.push_back(lead);
                outgoing.push_back(8'($urandom_range(0, 254)));
                outgoing.push_back(8'($urandom_range(0, 254)));

                length = 8'(2 * pairs + spare);
                if (kind == KIND_BAD_LENGTH)
                begin
                    wrong = length;
                    while (wrong == length)
                    begin
                        wrong = 8'($urandom_range(0, 254));
                    end
                    length = wrong;
                end
                outgoing.push_back(length);
                repeat (2 * pairs + spare) outgoing.push_back(rand_payload());

                // Clamped: choose the last payload byte so the XOR is 255
                if (kind == KIND_CLAMPED)
                begin
                    void'(outgoing.pop_back());
                    fold = fold_outgoing();
                    if (fold == 8'h00)
                    begin
                        outgoing[POS_NAME0] = (outgoing[POS_NAME0] == 8'h00) ? 8'h01 : 8'h00;
                        fold = fold_outgoing();
                    end
                    outgoing.push_back(fold ^ FRAME_END);
                end

                csum = fold_outgoing();
                if (csum == FRAME_END)
                begin
                    csum = CSUM_CLAMP;
                end
                if (kind == KIND_BAD_CSUM)
                begin
                    wrong = csum;
                    while (wrong == csum)
                    begin
                        wrong = 8'($urandom_range(0, 254));
                    end
                    csum = wrong;
                end
                outgoing.push_back(csum);
            end
        endcase
        outgoing.push_back(FRAME_END);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    byte_row_t  directed_rows[28];
    logic [7:0] phase_version[4];
    int         phase_budget[4];

    initial
    begin : stimulus
        frame_kind_e           kind;
        logic [APB_DATA_W-1:0] readback;
        int                    sent;
        int                    frames;

        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        byte_link.valid = 1'b0;
        byte_link.rx_byte = 8'h00;
        expected_version = VERSION_RESET;

        // Directed table. Only terminators carry a fixed expectation.
        directed_rows = '{
            // lone terminator straight after reset: short frame
            '{8'hFF, 1'b1, error_result(ST_BAD_LENGTH)},
            // extreme names and values, odd length with one trailing byte
            '{8'h30, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'hFE, 1'b0, '0},
            '{8'h03, 1'b0, '0}, '{8'hFE, 1'b0, '0}, '{8'hFE, 1'b0, '0},
            '{8'h7F, 1'b0, '0}, '{8'hB2, 1'b0, '0},
            '{8'hFF, 1'b1, '{ST_GOOD, 8'h00, 8'hFE, 15'd32766, 5'd0, 1'b1, 1'b1}},
            // no payload: one empty good result
            '{8'h30, 1'b0, '0}, '{8'h41, 1'b0, '0}, '{8'h42, 1'b0, '0},
            '{8'h00, 1'b0, '0}, '{8'h33, 1'b0, '0},
            '{8'hFF, 1'b1, '{ST_GOOD, 8'h41, 8'h42, 15'd0, 5'd0, 1'b0, 1'b1}},
            // version one off
            '{8'h31, 1'b0, '0}, '{8'h41, 1'b0, '0}, '{8'h42, 1'b0, '0},
            '{8'h00, 1'b0, '0}, '{8'h32, 1'b0, '0},
            '{8'hFF, 1'b1, error_result(ST_BAD_VERSION)},
            // checksum zero where 0x33 belongs
            '{8'h30, 1'b0, '0}, '{8'h41, 1'b0, '0}, '{8'h42, 1'b0, '0},
            '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
            '{8'hFF, 1'b1, error_result(ST_BAD_CSUM)}
        };

        phase_version = '{8'h00, FRAME_END, 8'($urandom_range(1, 254)), VERSION_RESET};
        phase_budget = '{70, 6, 100, 12};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        reg_read(VERSION_ADDR, readback);
        if (readback !== APB_DATA_W'(VERSION_RESET))
        begin
            $display("%0t ns: version register after reset, expected %0d, actual %0d",
                     $time, VERSION_RESET, readback);
            flow_errors++;
        end

        foreach (directed_rows[i])
        begin
            send_byte(directed_rows[i].rx, directed_rows[i].fixed, directed_rows[i].want);
        end
        stop_input();
        wait_results();

        // Random frames, one protocol version per phase. The store-filling
        // and overflowing frames count towards the byte budget.
        for (int phase = 0; phase < 4; phase++)
        begin
            no_gaps = (phase == 3);
            program_version(phase_version[phase]);
            sent = 0;
            frames = 0;
            while (sent < phase_budget[phase])
            begin
                if (phase == 0 && frames == 1)
                begin
                    kind = KIND_FULL;
                end
                else if (phase == 2 && frames == 0)
                begin
                    kind = KIND_OVERFLOW;
                end
                else
                begin
                    kind = pick_kind();
                end
                build_frame(kind, phase_version[phase]);
                send_frame();
                sent += outgoing.size();
                frames++;

                // receiver stalls while bytes keep coming
                if (phase == 2 && frames == 1)
                begin
                    hold_requests++;
                end
                // sender waits out every outstanding result mid-phase
                if (phase == 0 && frames == 1)
                begin
                    stop_input();
                    wait_results();
                end
            end
            stop_input();
            wait_results();
        end

        repeat (END_SETTLE) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0t ns: %0d expected result transactions left over",
                     $time, pending_results.size());
            flow_errors++;
        end

        $display("Checked %0d result transactions from %0d byte transactions, four versions.",
                 results_checked, bytes_accepted);
        $display("Frames: good %0d, bad version %0d, bad checksum %0d, %s %0d, %s %0d",
                 status_count[ST_GOOD], status_count[ST_BAD_VERSION],
                 status_count[ST_BAD_CSUM], "bad length", status_count[ST_BAD_LENGTH],
                 "overflow", status_count[ST_OVERFLOW]);
        if (check_errors + flow_errors == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/smd_pkg.sv
hdl/smd_byte_if.sv
hdl/smd_result_if.sv
hdl/smd_datapath.sv
hdl/smd_ctrl.sv
hdl/serial_message_deframer.sv
test/serial_message_deframer_test.sv
